// ----- src/bswc_pkg.sv -----
// ----------------------------------------------------------------------------
// bswc_pkg
// Types and constants shared by the bit stream writer with carry.
// ----------------------------------------------------------------------------
package bswc_pkg;

	typedef enum logic [2:0] {
		K_PUSH_BIT  = 3'd0,
		K_PUSH_NIB  = 3'd1,
		K_PUSH_BYTE = 3'd2,
		K_CARRY_BIT = 3'd3,
		K_CARRY_NIB = 3'd4,
		K_CARRY_BYT = 3'd5,
		K_READ      = 3'd6,
		K_CLEAR     = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FULL = 2'd1,
		STS_PAST = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_MODIFY,
		S_ZERO,
		S_RIP_RD,
		S_RIP_WR,
		S_OUT
	} state_t;

	localparam logic [7:0] MASK_HI  = 8'hf0;
	localparam logic [7:0] MASK_LO  = 8'h0f;
	localparam logic [7:0] NIB_LSB  = 8'h01;
	localparam logic [7:0] NIB_MSB  = 8'h10;
	localparam logic [7:0] BYTE_MAX = 8'hff;
	localparam logic [7:0] BIT_MSB  = 8'h80;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [11:0] read_address;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [12:0] byte_count;
		logic [2:0]  bit_position;
		logic [1:0]  status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    rd_en;
		logic    rd_pos;
		logic    do_push;
		logic    do_pbyte;
		logic    do_zero;
		logic    do_add;
		logic    do_ripple;
		logic    ld_pos;
		logic    do_clear;
		logic    cap_rd;
		logic    set_status;
		status_t status_code;
		logic    load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  tgt_oob;
		logic  rd_oob;
		logic  idx_zero;
		logic  tgt_zero;
		logic  pos_zero;
		logic  finished;
		logic  add_ovf;
		logic  data_ff;
		logic  out_free;
	} sts_t;

endpackage

// ----- src/bit_stream_writer_with_carry.sv -----
// ----------------------------------------------------------------------------
// bit_stream_writer_with_carry
// Output bit stream of an arithmetic coder: MSB-first packing of bits,
// nibbles and bytes into a byte store, with carry propagation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item (kind, value, read_address) on a valid/ready
//   handshake; rsp returns exactly one result item per request with the
//   read byte, the current byte count, bit position and status.
//   Items are handled one at a time by a sequencer around a single-port
//   byte store with a registered read. A clear, a push into a full store,
//   a read past the end of the store, a carry outside the store and a
//   byte carry at byte 0 go straight to the result. A carry ripples into
//   earlier bytes with a read and a write of the store for each byte.
//   The next item is taken in the cycle after the result is loaded into
//   the output register.
//   Reset clears the indices and makes byte 0 read as zero; no clearing
//   pass is needed. If rsp is stalled the result waits in the output
//   register, the block still takes and works on one more item and holds
//   it ready in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module bit_stream_writer_with_carry #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bswc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bswc_pkg::rsp_t rsp
);

	bswc_pkg::cmd_t cmd;
	bswc_pkg::sts_t sts;

	bswc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bswc_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- src/bswc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bswc_ctrl
// Sequencer for the bit stream writer: steps each item through decode,
// memory read, modify/write, carry ripple and result hand-off.
// ----------------------------------------------------------------------------
module bswc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  bswc_pkg::sts_t  sts,
	output bswc_pkg::cmd_t  cmd
);

	bswc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bswc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			bswc_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = bswc_pkg::S_DECODE;
				end
			end
			bswc_pkg::S_DECODE: begin
				case (sts.kind)
					bswc_pkg::K_PUSH_BIT, bswc_pkg::K_PUSH_NIB: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = bswc_pkg::STS_FULL;
							state_d         = bswc_pkg::S_OUT;
						end else begin
							state_d = bswc_pkg::S_READ;
						end
					end
					bswc_pkg::K_PUSH_BYTE: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = bswc_pkg::STS_FULL;
							state_d         = bswc_pkg::S_OUT;
						end else begin
							cmd.do_pbyte = 1'b1;
							state_d      = bswc_pkg::S_ZERO;
						end
					end
					bswc_pkg::K_CARRY_BIT, bswc_pkg::K_CARRY_NIB: begin
						if (sts.tgt_oob) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = bswc_pkg::STS_FULL;
							state_d         = bswc_pkg::S_OUT;
						end else begin
							state_d = bswc_pkg::S_READ;
						end
					end
					bswc_pkg::K_CARRY_BYT: begin
						if (sts.idx_zero) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = bswc_pkg::STS_PAST;
							state_d         = bswc_pkg::S_OUT;
						end else begin
							cmd.ld_pos = 1'b1;
							state_d    = bswc_pkg::S_RIP_RD;
						end
					end
					bswc_pkg::K_READ: begin
						state_d = sts.rd_oob ? bswc_pkg::S_OUT : bswc_pkg::S_READ;
					end
					default: begin
						cmd.do_clear = 1'b1;
						state_d      = bswc_pkg::S_OUT;
					end
				endcase
			end
			bswc_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = bswc_pkg::S_MODIFY;
			end
			bswc_pkg::S_MODIFY: begin
				case (sts.kind)
					bswc_pkg::K_PUSH_BIT, bswc_pkg::K_PUSH_NIB: begin
						cmd.do_push = 1'b1;
						state_d     = sts.finished ? bswc_pkg::S_ZERO : bswc_pkg::S_OUT;
					end
					bswc_pkg::K_CARRY_BIT, bswc_pkg::K_CARRY_NIB: begin
						cmd.do_add = 1'b1;
						state_d    = bswc_pkg::S_OUT;
						if (sts.add_ovf) begin
							if (sts.tgt_zero) begin
								cmd.set_status  = 1'b1;
								cmd.status_code = bswc_pkg::STS_PAST;
							end else begin
								state_d = bswc_pkg::S_RIP_RD;
							end
						end
					end
					default: begin
						cmd.cap_rd = 1'b1;
						state_d    = bswc_pkg::S_OUT;
					end
				endcase
			end
			bswc_pkg::S_ZERO: begin
				// no next byte to clear once the store is full
				cmd.do_zero = !sts.full;
				state_d     = bswc_pkg::S_OUT;
			end
			bswc_pkg::S_RIP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_pos = 1'b1;
				state_d    = bswc_pkg::S_RIP_WR;
			end
			bswc_pkg::S_RIP_WR: begin
				cmd.do_ripple = 1'b1;
				state_d       = bswc_pkg::S_OUT;
				if (sts.data_ff) begin
					if (sts.pos_zero) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = bswc_pkg::STS_PAST;
					end else begin
						state_d = bswc_pkg::S_RIP_RD;
					end
				end
			end
			bswc_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = bswc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bswc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/bswc_dp.sv -----
// ----------------------------------------------------------------------------
// bswc_dp
// Datapath: byte store, write indices, carry target and ripple pointer,
// and the result register.
// ----------------------------------------------------------------------------
module bswc_dp #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bswc_pkg::req_t  req,
	input  bswc_pkg::cmd_t  cmd,
	output bswc_pkg::sts_t  sts,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bswc_pkg::rsp_t  rsp
);

	localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int IDX_W = $clog2(STORE_DEPTH + 1);
	localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(STORE_DEPTH);
	localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);

	logic [7:0]       mem [STORE_DEPTH];
	logic [7:0]       mem_q;
	logic             rd_zero_q;
	logic             b0_zero_q;

	bswc_pkg::req_t   item_q;
	logic [IDX_W-1:0] byte_index_q;
	logic [2:0]       bit_index_q;
	logic [7:0]       last_mask_q;
	logic [AW-1:0]    pos_q;
	bswc_pkg::status_t status_q;
	logic [7:0]       rd_q;
	bswc_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	bswc_pkg::kind_t  kind;
	logic             full;
	logic             dec;
	logic [IDX_W-1:0] tgt;
	logic [7:0]       amount;
	logic [7:0]       rdata;
	logic [8:0]       sum;
	logic [7:0]       bit_mask;
	logic [7:0]       push_data;
	logic [7:0]       push_mask;
	logic [2:0]       push_next_bit;
	logic             finished;
	logic [AW-1:0]    raddr;
	logic             wr_en;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;

	assign kind  = bswc_pkg::kind_t'(item_q.kind);
	assign full  = byte_index_q >= DEPTH_I;
	assign rdata = rd_zero_q ? 8'h00 : mem_q;

	// carry target: step back a byte when the last bit or nibble push closed a byte
	always_comb begin
		dec    = 1'b0;
		amount = 8'h00;
		case (kind)
			bswc_pkg::K_CARRY_BIT: begin
				dec    = (byte_index_q != '0) && last_mask_q[0];
				amount = last_mask_q;
			end
			bswc_pkg::K_CARRY_NIB: begin
				dec    = (byte_index_q != '0) && (last_mask_q == bswc_pkg::MASK_LO);
				amount = (bit_index_q == 3'd0) ? bswc_pkg::NIB_LSB : bswc_pkg::NIB_MSB;
			end
			default: begin
				dec    = 1'b0;
				amount = 8'h00;
			end
		endcase
	end

	assign tgt = byte_index_q - {{(IDX_W-1){1'b0}}, dec};
	assign sum = {1'b0, rdata} + {1'b0, amount};

	// merge a bit or nibble into the current byte
	assign bit_mask = bswc_pkg::BIT_MSB >> bit_index_q;
	always_comb begin
		if (kind == bswc_pkg::K_PUSH_BIT) begin
			push_mask     = bit_mask;
			push_data     = (rdata & ~bit_mask) | (item_q.value[0] ? bit_mask : 8'h00);
			push_next_bit = bit_index_q + 3'd1;
			finished      = (bit_index_q == 3'd7);
		end else if (bit_index_q == 3'd0) begin
			push_mask     = bswc_pkg::MASK_HI;
			push_data     = {item_q.value[3:0], rdata[3:0]};
			push_next_bit = 3'd4;
			finished      = 1'b0;
		end else begin
			push_mask     = bswc_pkg::MASK_LO;
			push_data     = {rdata[7:4], item_q.value[3:0]};
			push_next_bit = 3'd0;
			finished      = 1'b1;
		end
	end

	always_comb begin
		if (cmd.rd_pos) begin
			raddr = pos_q;
		end else if (kind == bswc_pkg::K_READ) begin
			raddr = AW'(item_q.read_address);
		end else begin
			raddr = AW'(tgt);
		end
	end

	always_comb begin
		wr_en = 1'b1;
		waddr = AW'(byte_index_q);
		wdata = 8'h00;
		if (cmd.do_push) begin
			wdata = push_data;
		end else if (cmd.do_pbyte) begin
			wdata = item_q.value;
		end else if (cmd.do_zero) begin
			wdata = 8'h00;
		end else if (cmd.do_add) begin
			waddr = AW'(tgt);
			wdata = sum[7:0];
		end else if (cmd.do_ripple) begin
			waddr = pos_q;
			wdata = (rdata == bswc_pkg::BYTE_MAX) ? 8'h00 : rdata + 8'd1;
		end else if (cmd.do_clear) begin
			waddr = '0;
			wdata = 8'h00;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			mem_q     <= mem[raddr];
			rd_zero_q <= b0_zero_q && (raddr == '0);
		end
	end

	// byte 0 reads as zero from reset until it is first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_zero_q <= 1'b1;
		end else if (wr_en && (waddr == '0)) begin
			b0_zero_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			bit_index_q  <= 3'd0;
			last_mask_q  <= 8'h00;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.do_push) begin
				last_mask_q <= push_mask;
				bit_index_q <= push_next_bit;
				if (finished) begin
					byte_index_q <= byte_index_q + ONE_I;
				end
			end else if (cmd.do_pbyte) begin
				byte_index_q <= byte_index_q + ONE_I;
			end else if (cmd.do_clear) begin
				byte_index_q <= '0;
				bit_index_q  <= 3'd0;
				last_mask_q  <= 8'h00;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= req;
			status_q <= bswc_pkg::STS_OK;
			rd_q     <= 8'h00;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.cap_rd) begin
			rd_q <= rdata;
		end
		if (cmd.do_add) begin
			pos_q <= AW'(tgt - ONE_I);
		end else if (cmd.ld_pos) begin
			pos_q <= AW'(byte_index_q - ONE_I);
		end else if (cmd.do_ripple) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.load_out) begin
			rsp_q.read_data    <= rd_q;
			rsp_q.byte_count   <= 13'(byte_index_q);
			rsp_q.bit_position <= bit_index_q;
			rsp_q.status       <= status_q;
		end
	end

	always_comb begin
		sts          = '0;
		sts.kind     = kind;
		sts.full     = full;
		sts.tgt_oob  = tgt >= DEPTH_I;
		sts.rd_oob   = 32'(item_q.read_address) >= 32'(STORE_DEPTH);
		sts.idx_zero = (byte_index_q == '0);
		sts.tgt_zero = (tgt == '0);
		sts.pos_zero = (pos_q == '0);
		sts.finished = finished;
		sts.add_ovf  = sum[8];
		sts.data_ff  = (rdata == bswc_pkg::BYTE_MAX);
		sts.out_free = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- dv/tb_bit_stream_writer_with_carry.sv -----
// ----------------------------------------------------------------------------
// tb_bit_stream_writer_with_carry
// Self-checking bench for the bit stream writer: a short table of hand-picked
// items, then random coder-like traffic with frequent carries and clears.
// Every result is compared against its row's expected result or an in-bench model.
// ----------------------------------------------------------------------------
module tb_bit_stream_writer_with_carry;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam logic [12:0] DEPTH_C = 13'(STORE_DEPTH);
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		bswc_pkg::kind_t kind;
		logic [7:0]      value;
		logic [11:0]     addr;
		logic            typed;
		bswc_pkg::rsp_t  want;
	} step_t;

	// rows with typed set carry their own expected result
	localparam step_t OPENING [28] = '{
		'{bswc_pkg::K_READ,      8'h00, 12'h000, 1'b1, '{8'h00, 13'd0, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_CARRY_BYT, 8'h00, 12'h000, 1'b1,
			'{8'h00, 13'd0, 3'd0, bswc_pkg::STS_PAST}},
		'{bswc_pkg::K_CARRY_BIT, 8'h00, 12'hfff, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BIT,  8'h01, 12'h000, 1'b1, '{8'h00, 13'd0, 3'd1, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_PUSH_BIT,  8'hfe, 12'hfff, 1'b0, '0},
		'{bswc_pkg::K_CARRY_BIT, 8'h00, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_NIB,  8'hff, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_CARRY_NIB, 8'h00, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_NIB,  8'ha0, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BYTE, 8'h3c, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_CARRY_NIB, 8'h00, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_READ,      8'h00, 12'h001, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BIT,  8'h01, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BIT,  8'h00, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BIT,  8'h01, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BIT,  8'h01, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_CARRY_BIT, 8'h00, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_PUSH_BYTE, 8'hff, 12'h000, 1'b0, '0},
		'{bswc_pkg::K_CLEAR,     8'h00, 12'h000, 1'b1, '{8'h00, 13'd0, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_PUSH_BYTE, 8'hff, 12'h000, 1'b1, '{8'h00, 13'd1, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_PUSH_BYTE, 8'hff, 12'h000, 1'b1, '{8'h00, 13'd2, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_CARRY_BYT, 8'h00, 12'h000, 1'b1,
			'{8'h00, 13'd2, 3'd0, bswc_pkg::STS_PAST}},
		'{bswc_pkg::K_READ,      8'h00, 12'h000, 1'b1, '{8'h00, 13'd2, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_CLEAR,     8'hff, 12'hfff, 1'b1, '{8'h00, 13'd0, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_PUSH_BYTE, 8'hff, 12'h000, 1'b1, '{8'h00, 13'd1, 3'd0, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_PUSH_NIB,  8'h0f, 12'h000, 1'b1, '{8'h00, 13'd1, 3'd4, bswc_pkg::STS_OK}},
		'{bswc_pkg::K_CARRY_NIB, 8'h00, 12'h000, 1'b1,
			'{8'h00, 13'd1, 3'd4, bswc_pkg::STS_PAST}},
		'{bswc_pkg::K_PUSH_BYTE, 8'h00, 12'h000, 1'b0, '0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_ready;
	bswc_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bswc_pkg::rsp_t rsp;

	// shadow of the writer state
	logic [7:0]  store_img [STORE_DEPTH];
	logic [12:0] fill_idx = '0;
	logic [2:0]  fill_bit = '0;
	logic [7:0]  last_mask_q = '0;
	int          written_top = 0;

	bswc_pkg::rsp_t writer_rsp_q [$];
	int   fault_count = 0;
	int   cycle_count = 0;
	bit   calm = 1'b0;

	bit_stream_writer_with_carry #(.STORE_DEPTH(STORE_DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** bit_stream_writer_with_carry: FAILED **");
		$finish;
	end

	function automatic bswc_pkg::status_t ripple_up(int pos);
		while (pos >= 0 && store_img[AW'(pos)] == bswc_pkg::BYTE_MAX) begin
			store_img[AW'(pos)] = 8'h00;
			pos--;
		end
		if (pos < 0)
			return bswc_pkg::STS_PAST;
		store_img[AW'(pos)] = store_img[AW'(pos)] + 8'd1;
		return bswc_pkg::STS_OK;
	endfunction

	function automatic bswc_pkg::status_t add_into(int at, logic [7:0] amount);
		logic [8:0] sum;
		if (at >= STORE_DEPTH)
			return bswc_pkg::STS_FULL;
		sum = {1'b0, store_img[AW'(at)]} + {1'b0, amount};
		store_img[AW'(at)] = sum[7:0];
		if (sum[8])
			return ripple_up(at - 1);
		return bswc_pkg::STS_OK;
	endfunction

	function automatic void close_byte();
		fill_bit = 3'd0;
		fill_idx = fill_idx + 13'd1;
		if (fill_idx < DEPTH_C)
			store_img[fill_idx[AW-1:0]] = 8'h00;
	endfunction

	function automatic bswc_pkg::rsp_t stream_predict(bswc_pkg::req_t r);
		bswc_pkg::rsp_t    o;
		logic [7:0]        m;
		int                at;
		bswc_pkg::status_t st;
		o = '0;
		st = bswc_pkg::STS_OK;
		case (r.kind)
			bswc_pkg::K_PUSH_BIT: begin
				if (fill_idx >= DEPTH_C) begin
					st = bswc_pkg::STS_FULL;
				end else begin
					m = bswc_pkg::BIT_MSB >> fill_bit;
					last_mask_q = m;
					store_img[fill_idx[AW-1:0]] = r.value[0]
						? (store_img[fill_idx[AW-1:0]] | m)
						: (store_img[fill_idx[AW-1:0]] & ~m);
					if (fill_bit == 3'd7)
						close_byte();
					else
						fill_bit = fill_bit + 3'd1;
				end
			end
			bswc_pkg::K_PUSH_NIB: begin
				if (fill_idx >= DEPTH_C) begin
					st = bswc_pkg::STS_FULL;
				end else if (fill_bit == 3'd0) begin
					last_mask_q = bswc_pkg::MASK_HI;
					store_img[fill_idx[AW-1:0]] =
						{r.value[3:0], store_img[fill_idx[AW-1:0]][3:0]};
					fill_bit = 3'd4;
				end else begin
					// misaligned nibble lands in the low half and closes the byte
					last_mask_q = bswc_pkg::MASK_LO;
					store_img[fill_idx[AW-1:0]] =
						{store_img[fill_idx[AW-1:0]][7:4], r.value[3:0]};
					close_byte();
				end
			end
			bswc_pkg::K_PUSH_BYTE: begin
				if (fill_idx >= DEPTH_C) begin
					st = bswc_pkg::STS_FULL;
				end else begin
					store_img[fill_idx[AW-1:0]] = r.value;
					fill_idx = fill_idx + 13'd1;
					if (fill_idx < DEPTH_C)
						store_img[fill_idx[AW-1:0]] = 8'h00;
				end
			end
			bswc_pkg::K_CARRY_BIT: begin
				at = int'(fill_idx);
				if (at > 0 && last_mask_q[0])
					at--;
				st = add_into(at, last_mask_q);
			end
			bswc_pkg::K_CARRY_NIB: begin
				at = int'(fill_idx);
				if (at > 0 && last_mask_q == bswc_pkg::MASK_LO)
					at--;
				st = add_into(at, (fill_bit == 3'd0) ? bswc_pkg::NIB_LSB : bswc_pkg::NIB_MSB);
			end
			bswc_pkg::K_CARRY_BYT: begin
				if (fill_idx == 13'd0)
					st = bswc_pkg::STS_PAST;
				else
					st = ripple_up(int'(fill_idx) - 1);
			end
			bswc_pkg::K_READ: begin
				if (32'(r.read_address) < STORE_DEPTH)
					o.read_data = store_img[r.read_address];
			end
			default: begin
				fill_idx = '0;
				fill_bit = '0;
				last_mask_q = '0;
				store_img[0] = 8'h00;
			end
		endcase
		if (fill_idx < DEPTH_C && int'(fill_idx) > written_top)
			written_top = int'(fill_idx);
		o.byte_count = fill_idx;
		o.bit_position = fill_bit;
		o.status = st;
		return o;
	endfunction

	// coder-like traffic: runs of ones so carries ripple, clears keep the stream short
	function automatic bswc_pkg::req_t random_item();
		bswc_pkg::req_t r;
		int   roll;
		r.value = 8'($urandom_range(0, 255));
		r.read_address = 12'($urandom_range(0, 4095));
		roll = $urandom_range(0, 99);
		if (fill_idx > 13'd40 || roll < 3) begin
			r.kind = bswc_pkg::K_CLEAR;
		end else if (roll < 33) begin
			r.kind = bswc_pkg::K_PUSH_BIT;
		end else if (roll < 48) begin
			r.kind = bswc_pkg::K_PUSH_NIB;
			if ($urandom_range(0, 2) == 0)
				r.value[3:0] = bswc_pkg::MASK_LO[3:0];
		end else if (roll < 68) begin
			r.kind = bswc_pkg::K_PUSH_BYTE;
			if ($urandom_range(0, 2) == 0)
				r.value = bswc_pkg::BYTE_MAX;
		end else if (roll < 76) begin
			r.kind = bswc_pkg::K_CARRY_BIT;
		end else if (roll < 84) begin
			r.kind = bswc_pkg::K_CARRY_NIB;
		end else if (roll < 92) begin
			r.kind = bswc_pkg::K_CARRY_BYT;
		end else begin
			r.kind = bswc_pkg::K_READ;
			r.read_address = 12'($urandom_range(0, written_top));
		end
		return r;
	endfunction

	task automatic send_item(input bswc_pkg::req_t item, input logic typed,
			input bswc_pkg::rsp_t want);
		bswc_pkg::rsp_t guess;
		if (!calm) begin
			while ($urandom_range(0, 99) < 9) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		guess = stream_predict(item);
		writer_rsp_q.push_back(typed ? want : guess);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (writer_rsp_q.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= calm || ($urandom_range(0, 99) >= 9);
	end

	always @(posedge clk) begin
		bswc_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (writer_rsp_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: rd=%h cnt=%0d pos=%0d st=%0d",
						rsp.read_data, rsp.byte_count, rsp.bit_position, rsp.status);
			end else begin
				want = writer_rsp_q.pop_front();
				if (rsp.read_data !== want.read_data || rsp.byte_count !== want.byte_count
						|| rsp.bit_position !== want.bit_position
						|| rsp.status !== want.status) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch %0t: exp rd=%h cnt=%0d pos=%0d st=%0d",
							$realtime, want.read_data, want.byte_count,
							want.bit_position, want.status,
							" got rd=%h cnt=%0d pos=%0d st=%0d",
							rsp.read_data, rsp.byte_count, rsp.bit_position,
							rsp.status);
				end
			end
		end
	end

	initial begin
		bswc_pkg::req_t item;
		req_valid = 1'b0;
		req = '0;
		foreach (store_img[i])
			store_img[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i]) begin
			item.kind = OPENING[i].kind;
			item.value = OPENING[i].value;
			item.read_address = OPENING[i].addr;
			send_item(item, OPENING[i].typed, OPENING[i].want);
		end

		// back-to-back stretch, then random idling on both sides
		calm = 1'b1;
		repeat (300)
			send_item(random_item(), 1'b0, '0);
		calm = 1'b0;
		wait_drained();
		repeat (600)
			send_item(random_item(), 1'b0, '0);

		wait_drained();
		repeat (20)
			send_item(random_item(), 1'b0, '0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fault_count == 0 && writer_rsp_q.size() == 0)
			$display("** bit_stream_writer_with_carry: PASSED **");
		else
			$display("** bit_stream_writer_with_carry: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
src/bswc_pkg.sv
src/bswc_ctrl.sv
src/bswc_dp.sv
src/bit_stream_writer_with_carry.sv
dv/tb_bit_stream_writer_with_carry.sv
